// ----- rtl/core/ybox_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ybox_pkg
// Shared constants, register map and types for the YUV to RGB565 box overlay.
// ----------------------------------------------------------------------------
package ybox_pkg;

    localparam int DISPLAY_WIDTH  = 320;
    localparam int DISPLAY_HEIGHT = 240;
    localparam int MAX_BOXES      = 4;
    localparam int NUM_SLOTS      = 4;

    localparam int COL_W    = $clog2(DISPLAY_WIDTH);
    localparam int ROW_W    = $clog2(DISPLAY_HEIGHT);
    localparam int COORD_W  = 10;
    localparam int CORNER_W = 4 * COORD_W;

    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_BOX_COUNT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_EDGE_COLOR = 3'd1;
    localparam logic [IDX_W-1:0] REG_BOX0       = 3'd2;
    localparam logic [IDX_W-1:0] REG_BOX1       = 3'd3;
    localparam logic [IDX_W-1:0] REG_BOX2       = 3'd4;
    localparam logic [IDX_W-1:0] REG_BOX3       = 3'd5;

    // BT.601 limited-range coefficients (8.8 fixed point)
    localparam logic signed [19:0] CSC_KY     = 20'sd298;
    localparam logic signed [19:0] CSC_KRV    = 20'sd409;
    localparam logic signed [19:0] CSC_KGU    = 20'sd100;
    localparam logic signed [19:0] CSC_KGV    = 20'sd208;
    localparam logic signed [19:0] CSC_KBU    = 20'sd516;
    localparam logic signed [19:0] CSC_ROUND  = 20'sd128;
    localparam logic signed [9:0]  LUMA_BLACK = 10'sd16;

    typedef struct packed {
        logic [2:0]                               box_count;
        logic [15:0]                              edge_color;
        logic [NUM_SLOTS-1:0][CORNER_W-1:0]       corners;
    } ybox_cfg_t;

endpackage : ybox_pkg
`default_nettype wire

// ----- rtl/core/yuv_to_rgb565_box_overlay.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_to_rgb565_box_overlay
// Pixel stream converter: YCbCr to RGB565 with up to four box outlines.
// Pipeline: input beat held in the input reg, then converted into the result reg.
// Throughput: one beat per cycle unless output stalls; CSC and box tests run in parallel.
// Reset: raster counters, cfg regs, both stage valids clear to zero; data regs do not.
// ----------------------------------------------------------------------------
module yuv_to_rgb565_box_overlay
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // APB
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ybox_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ybox_pkg::DATA_W-1:0] pwdata,
    output logic      [ybox_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    // input stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [23:0]                 s_axis_tdata,  // luma, cb_offset, cr_offset
    input  wire logic                        s_axis_tuser,  // frame_start
    // output stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [15:0]                 m_axis_tdata,  // rgb565
    output logic                             m_axis_tuser,  // on_edge
    output logic                             m_axis_tlast   // frame_end
);
    import ybox_pkg::*;

    ybox_cfg_t          cfg;
    logic               in_accept, advance;
    logic [COL_W-1:0]   pix_col;
    logic [ROW_W-1:0]   pix_row;
    logic               pix_last;

    logic               s1_valid_reg;
    logic [7:0]         s1_luma_reg, s1_cb_reg, s1_cr_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_last_reg;

    logic               out_valid_reg;
    logic [15:0]        out_pix_reg;
    logic               out_edge_reg, out_last_reg;

    logic [15:0]        csc_pix;
    logic [MAX_BOXES-1:0] box_hit, box_en;
    logic [2:0]         n_boxes;
    logic               edge_hit;

    ybox_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    ybox_raster u_raster
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .frame_start (s_axis_tuser),
        .pix_col     (pix_col),
        .pix_row     (pix_row),
        .pix_last    (pix_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_luma_reg <= s_axis_tdata[7:0];
            s1_cb_reg   <= s_axis_tdata[15:8];
            s1_cr_reg   <= s_axis_tdata[23:16];
            s1_col_reg  <= pix_col;
            s1_row_reg  <= pix_row;
            s1_last_reg <= pix_last;
        end
    end

    ybox_csc u_csc
    (
        .luma      (s1_luma_reg),
        .cb_offset (s1_cb_reg),
        .cr_offset (s1_cr_reg),
        .rgb565    (csc_pix)
    );

    assign n_boxes = (cfg.box_count > 3'(MAX_BOXES)) ? 3'(MAX_BOXES) : cfg.box_count;

    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_box
        assign box_en[i] = 3'(i) < n_boxes;

        ybox_hit u_hit
        (
            .corners (cfg.corners[i]),
            .col     (s1_col_reg),
            .row     (s1_row_reg),
            .hit     (box_hit[i])
        );
    end

    assign edge_hit = |(box_hit & box_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_pix_reg  <= edge_hit ? cfg.edge_color : csc_pix;
            out_edge_reg <= edge_hit;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tuser  = out_edge_reg;
    assign m_axis_tlast  = out_last_reg;

    // frame end marks only the last column of the last row
    a_last_pos : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg |->
            s1_col_reg == COL_W'(DISPLAY_WIDTH - 1)
            && s1_row_reg == ROW_W'(DISPLAY_HEIGHT - 1))
        else $error("frame end flagged off the last pixel");

    // a full pipe facing a stalled sink must stop taking beats
    a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input beat taken with both stages full and output stalled");

    // a waiting stage 1 beat is never dropped
    a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_col_reg)
            && $stable(s1_row_reg))
        else $error("stage 1 beat lost during output stall");

    // every held position stays on the display
    a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_col_reg < COL_W'(DISPLAY_WIDTH)
            && s1_row_reg < ROW_W'(DISPLAY_HEIGHT))
        else $error("raster position outside the display");

endmodule : yuv_to_rgb565_box_overlay
`default_nettype wire

// ----- rtl/core/ybox_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ybox_regs
// APB register bank: box count, box color and four corner registers.
// ----------------------------------------------------------------------------
module ybox_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ybox_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ybox_pkg::DATA_W-1:0] pwdata,
    output logic      [ybox_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output ybox_pkg::ybox_cfg_t              cfg
);
    import ybox_pkg::*;

    ybox_cfg_t        cfg_reg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[ADDR_W-1:3];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_BOX_COUNT:  cfg_reg.box_count  <= pwdata[2:0];
                REG_EDGE_COLOR: cfg_reg.edge_color <= pwdata[15:0];
                REG_BOX0:       cfg_reg.corners[0] <= pwdata[CORNER_W-1:0];
                REG_BOX1:       cfg_reg.corners[1] <= pwdata[CORNER_W-1:0];
                REG_BOX2:       cfg_reg.corners[2] <= pwdata[CORNER_W-1:0];
                REG_BOX3:       cfg_reg.corners[3] <= pwdata[CORNER_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BOX_COUNT:  prdata = DATA_W'(cfg_reg.box_count);
            REG_EDGE_COLOR: prdata = DATA_W'(cfg_reg.edge_color);
            REG_BOX0:       prdata = DATA_W'(cfg_reg.corners[0]);
            REG_BOX1:       prdata = DATA_W'(cfg_reg.corners[1]);
            REG_BOX2:       prdata = DATA_W'(cfg_reg.corners[2]);
            REG_BOX3:       prdata = DATA_W'(cfg_reg.corners[3]);
            default:        prdata = '0;
        endcase
    end

endmodule : ybox_regs
`default_nettype wire

// ----- rtl/core/ybox_raster.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ybox_raster
// Column/row raster counters; gives the position of each accepted beat.
// ----------------------------------------------------------------------------
module ybox_raster
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic                       frame_start,
    output logic      [ybox_pkg::COL_W-1:0] pix_col,
    output logic      [ybox_pkg::ROW_W-1:0] pix_row,
    output logic                            pix_last
);
    import ybox_pkg::*;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(DISPLAY_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(DISPLAY_HEIGHT - 1);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    assign pix_col  = frame_start ? '0 : col_reg;
    assign pix_row  = frame_start ? '0 : row_reg;
    assign pix_last = (pix_col == COL_LAST) && (pix_row == ROW_LAST);

    always_comb
    begin
        if (pix_col >= COL_LAST)
        begin
            col_next = '0;
            row_next = (pix_row >= ROW_LAST) ? '0 : pix_row + 1'b1;
        end
        else
        begin
            col_next = pix_col + 1'b1;
            row_next = pix_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule : ybox_raster
`default_nettype wire

// ----- rtl/core/ybox_hit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ybox_hit
// Edge-band test of one box: 3-pixel frame, far corner clamped to display.
// ----------------------------------------------------------------------------
module ybox_hit
(
    input  wire logic [ybox_pkg::CORNER_W-1:0] corners,
    input  wire logic [ybox_pkg::COL_W-1:0]    col,
    input  wire logic [ybox_pkg::ROW_W-1:0]    row,
    output logic                               hit
);
    import ybox_pkg::*;

    localparam int CMP_W = COORD_W + 1;
    localparam logic [COORD_W-1:0] X_LIMIT = COORD_W'(DISPLAY_WIDTH);
    localparam logic [COORD_W-1:0] Y_LIMIT = COORD_W'(DISPLAY_HEIGHT);
    localparam logic [COORD_W-1:0] X_LAST  = COORD_W'(DISPLAY_WIDTH - 1);
    localparam logic [COORD_W-1:0] Y_LAST  = COORD_W'(DISPLAY_HEIGHT - 1);
    localparam logic [CMP_W-1:0]   BAND    = CMP_W'(2);

    logic [COORD_W-1:0] x0, y0, x1, y1, x1c, y1c;
    logic [CMP_W-1:0]   x0e, y0e, x1e, y1e, c, r, c2, r2, x0p2, y0p2;
    logic               on_h, on_v, in_x, in_y;

    assign x0  = corners[COORD_W-1:0];
    assign y0  = corners[2*COORD_W-1:COORD_W];
    assign x1  = corners[3*COORD_W-1:2*COORD_W];
    assign y1  = corners[4*COORD_W-1:3*COORD_W];
    assign x1c = (x1 >= X_LIMIT) ? X_LAST : x1;
    assign y1c = (y1 >= Y_LIMIT) ? Y_LAST : y1;

    assign x0e  = {1'b0, x0};
    assign y0e  = {1'b0, y0};
    assign x1e  = {1'b0, x1c};
    assign y1e  = {1'b0, y1c};
    assign c    = CMP_W'(col);
    assign r    = CMP_W'(row);
    assign c2   = c + BAND;
    assign r2   = r + BAND;
    assign x0p2 = x0e + BAND;
    assign y0p2 = y0e + BAND;

    // near edge: v in [lo, lo+2]; far edge: v in [hi-2, hi] as v+2 >= hi
    assign on_h = (r >= y0e && r <= y0p2) || (r2 >= y1e && r <= y1e);
    assign on_v = (c >= x0e && c <= x0p2) || (c2 >= x1e && c <= x1e);
    assign in_x = (c >= x0e) && (c <= x1e);
    assign in_y = (r >= y0e) && (r <= y1e);
    assign hit  = (on_h && in_x) || (on_v && in_y);

endmodule : ybox_hit
`default_nettype wire

// ----- rtl/core/ybox_csc.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ybox_csc
// BT.601 limited-range YCbCr to RGB with 0..255 clamp, packed to RGB565.
// ----------------------------------------------------------------------------
module ybox_csc
(
    input  wire logic [7:0]  luma,
    input  wire logic [7:0]  cb_offset,
    input  wire logic [7:0]  cr_offset,
    output logic      [15:0] rgb565
);
    import ybox_pkg::*;

    function automatic logic [7:0] clamp8(input logic signed [19:0] s);
        logic [7:0] res;
        if (s[19])
            res = 8'd0;
        else if (|s[18:16])
            res = 8'hFF;
        else
            res = s[15:8];
        return res;
    endfunction

    logic signed [9:0]  yy;
    logic signed [19:0] yy_x, u_x, v_x;
    logic signed [19:0] prod_y, prod_rv, prod_gu, prod_gv, prod_bu;
    logic signed [19:0] sum_r, sum_g, sum_b;
    logic        [7:0]  red, grn, blu;

    assign yy   = $signed({2'b00, luma}) - LUMA_BLACK;
    assign yy_x = $signed({{10{yy[9]}}, yy});
    assign u_x  = $signed({{12{cb_offset[7]}}, cb_offset});
    assign v_x  = $signed({{12{cr_offset[7]}}, cr_offset});

    assign prod_y  = yy_x * CSC_KY;
    assign prod_rv = v_x * CSC_KRV;
    assign prod_gu = u_x * CSC_KGU;
    assign prod_gv = v_x * CSC_KGV;
    assign prod_bu = u_x * CSC_KBU;

    assign sum_r = prod_y + prod_rv + CSC_ROUND;
    assign sum_g = prod_y - prod_gu - prod_gv + CSC_ROUND;
    assign sum_b = prod_y + prod_bu + CSC_ROUND;

    assign red = clamp8(sum_r);
    assign grn = clamp8(sum_g);
    assign blu = clamp8(sum_b);

    assign rgb565 = {red[7:3], grn[7:2], blu[7:3]};

endmodule : ybox_csc
`default_nettype wire

// ----- dv/ybox_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ybox_checker
// Watches the register port and both pixel streams of the box overlay
// converter. Keeps its own copy of the registers and raster position,
// predicts every output pixel and compares each output beat in order.
// ----------------------------------------------------------------------------
module ybox_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [ybox_pkg::ADDR_W-1:0] paddr,
    input  logic [ybox_pkg::DATA_W-1:0] pwdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // luma, cb_offset, cr_offset
    input  logic                        s_tuser,   // frame_start
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [15:0]                 m_tdata,   // rgb565
    input  logic                        m_tuser,   // on_edge
    input  logic                        m_tlast,   // frame_end
    output logic [31:0]                 fail_count,
    output logic [31:0]                 pending,
    output logic [31:0]                 pixels_checked,
    output logic [31:0]                 edge_pixels,
    output logic [31:0]                 frame_ends
);

    import ybox_pkg::*;

    typedef struct packed {
        logic [15:0] rgb565;
        logic        on_edge;
        logic        frame_end;
    } pixel_out_t;

    pixel_out_t          expected_pixels[$];
    logic [2:0]          cfg_count;
    logic [15:0]         cfg_color;
    logic [CORNER_W-1:0] cfg_corners[NUM_SLOTS];
    logic [COL_W-1:0]    col_q;
    logic [ROW_W-1:0]    row_q;

    function automatic logic [7:0] clamp_chan(input int sum);
        int s;
        if (sum < 0)
            return 8'd0;
        s = sum >>> 8;
        return (s > 255) ? 8'hFF : s[7:0];
    endfunction

    function automatic bit box_hit(input logic [CORNER_W-1:0] corners, input int c, input int r);
        int x0, y0, x1, y1;
        bit on_h, on_v;
        x0 = corners[0 +: COORD_W];
        y0 = corners[COORD_W +: COORD_W];
        x1 = corners[2*COORD_W +: COORD_W];
        y1 = corners[3*COORD_W +: COORD_W];
        if (x1 >= DISPLAY_WIDTH)
            x1 = DISPLAY_WIDTH - 1;
        if (y1 >= DISPLAY_HEIGHT)
            y1 = DISPLAY_HEIGHT - 1;
        on_h = (r >= y0 && r <= y0 + 2) || (r >= y1 - 2 && r <= y1);
        on_v = (c >= x0 && c <= x0 + 2) || (c >= x1 - 2 && c <= x1);
        return (on_h && c >= x0 && c <= x1) || (on_v && r >= y0 && r <= y1);
    endfunction

    function automatic pixel_out_t convert_pixel(input logic [7:0] luma,
                                                 input logic signed [7:0] cb,
                                                 input logic signed [7:0] cr,
                                                 input int c, input int r);
        pixel_out_t px;
        int yy, u, v, n;
        logic [7:0] red, grn, blu;
        bit hit;
        n = (cfg_count > MAX_BOXES) ? MAX_BOXES : cfg_count;
        hit = 1'b0;
        for (int i = 0; i < n; i++)
            if (box_hit(cfg_corners[i], c, r))
                hit = 1'b1;
        yy = int'(luma) - 16;
        u = cb;
        v = cr;
        red = clamp_chan(yy * 298 + v * 409 + 128);
        grn = clamp_chan(yy * 298 - u * 100 - v * 208 + 128);
        blu = clamp_chan(yy * 298 + u * 516 + 128);
        px.rgb565 = hit ? cfg_color : {red[7:3], grn[7:2], blu[7:3]};
        px.on_edge = hit;
        px.frame_end = (c == DISPLAY_WIDTH - 1) && (r == DISPLAY_HEIGHT - 1);
        return px;
    endfunction

    task automatic flag(input string field, input int want, input int got);
        fail_count = fail_count + 1;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    endtask

    // All stimulus changes on the rising edge, so the falling edge sees
    // exactly what the next rising edge will accept.
    always @(negedge clk)
    begin
        pixel_out_t want;
        int c, r;
        if (!rst_n)
        begin
            expected_pixels.delete();
            cfg_count = '0;
            cfg_color = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                cfg_corners[i] = '0;
            col_q = '0;
            row_q = '0;
            fail_count = 0;
            pixels_checked = 0;
            edge_pixels = 0;
            frame_ends = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[IDX_W+2:3])
                    REG_BOX_COUNT:  cfg_count = pwdata[2:0];
                    REG_EDGE_COLOR: cfg_color = pwdata[15:0];
                    REG_BOX0:       cfg_corners[0] = pwdata[CORNER_W-1:0];
                    REG_BOX1:       cfg_corners[1] = pwdata[CORNER_W-1:0];
                    REG_BOX2:       cfg_corners[2] = pwdata[CORNER_W-1:0];
                    REG_BOX3:       cfg_corners[3] = pwdata[CORNER_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                    flag("unexpected beat rgb565", 0, m_tdata);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_tdata !== want.rgb565)
                        flag("rgb565", want.rgb565, m_tdata);
                    if (m_tuser !== want.on_edge)
                        flag("on_edge", want.on_edge, m_tuser);
                    if (m_tlast !== want.frame_end)
                        flag("frame_end", want.frame_end, m_tlast);
                    pixels_checked = pixels_checked + 1;
                    if (want.on_edge)
                        edge_pixels = edge_pixels + 1;
                    if (want.frame_end)
                        frame_ends = frame_ends + 1;
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                begin
                    col_q = '0;
                    row_q = '0;
                end
                c = col_q;
                r = row_q;
                expected_pixels.push_back(convert_pixel(s_tdata[7:0], s_tdata[15:8],
                                                        s_tdata[23:16], c, r));
                if (c >= DISPLAY_WIDTH - 1)
                begin
                    col_q = '0;
                    row_q = (r >= DISPLAY_HEIGHT - 1) ? '0 : row_q + 1'b1;
                end
                else
                    col_q = col_q + 1'b1;
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the box overlay converter: directed color extremes, register corner
// cases, a multi-row run at full rate, then random pixels over several
// random box settings with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

    import ybox_pkg::*;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS  = 125;
    localparam int IDLE_PCT      = 36;
    localparam int HOLD_PHASE    = 3;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SWEEP_PIXELS  = 3 * DISPLAY_WIDTH + 4;

    // indexes past the register list; writes there must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE0 = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE1 = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata = '0;    // luma, cb_offset, cr_offset
    logic              s_axis_tuser = 1'b0;  // frame_start
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;         // rgb565
    logic              m_axis_tuser;         // on_edge
    logic              m_axis_tlast;         // frame_end

    logic [31:0] fail_count, pending, pixels_checked, edge_pixels, frame_ends;
    bit          steady = 1'b0;
    int          phase_id = -1;
    int          pixels_sent = 0;
    int          reg_writes = 0;
    int          cycle_count = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    yuv_to_rgb565_box_overlay dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ybox_checker pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tuser        (s_axis_tuser),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tuser        (m_axis_tuser),
        .m_tlast        (m_axis_tlast),
        .fail_count     (fail_count),
        .pending        (pending),
        .pixels_checked (pixels_checked),
        .edge_pixels    (edge_pixels),
        .frame_ends     (frame_ends)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    task automatic send_pixel(input logic [7:0] luma, input logic [7:0] cb,
                              input logic [7:0] cr, input logic fs);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cr, cb, luma};
        s_axis_tuser  <= fs;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        pixels_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CORNER_W-1:0] rand_corners();
        logic [COORD_W-1:0] x0, y0, x1, y1;
        int sel;
        sel = $urandom_range(7);
        x0 = COORD_W'($urandom_range(330));
        y0 = COORD_W'($urandom_range(7));
        x1 = x0 + COORD_W'($urandom_range(40));
        y1 = y0 + COORD_W'($urandom_range(8));
        case (sel)
            0:
            begin
                x0 = COORD_W'($urandom_range(1023));
                y0 = COORD_W'($urandom_range(1023));
                x1 = COORD_W'($urandom_range(1023));
                y1 = COORD_W'($urandom_range(1023));
            end
            1: x1 = '1;
            2: x0 = x1 + 10'd3;
            3: y1 = '1;
            default: ;
        endcase
        return {y1, x1, y0, x0};
    endfunction

    // output side: random stalls, one long hold-off, none during the sweep
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held && phase_id == HOLD_PHASE)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        logic [2:0]  cnt;
        logic [15:0] color;
        logic        fs;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: no boxes, conversion extremes
        send_pixel(8'd0,   8'h80, 8'h80, 1'b1);
        send_pixel(8'd255, 8'h7F, 8'h7F, 1'b0);
        send_pixel(8'd16,  8'h00, 8'h00, 1'b0);
        send_pixel(8'd235, 8'h00, 8'h00, 1'b0);
        send_pixel(8'd0,   8'h7F, 8'h80, 1'b0);
        send_pixel(8'd255, 8'h80, 8'h7F, 1'b0);
        send_pixel(8'd128, 8'h80, 8'h00, 1'b0);
        send_pixel(8'd128, 8'h7F, 8'h00, 1'b0);
        send_pixel(8'd128, 8'h00, 8'h7F, 1'b0);
        send_pixel(8'd128, 8'h00, 8'h80, 1'b1);
        settle();

        // count above the slot count, inverted box, box starting off screen,
        // box clamped to the screen border, small box near the top left
        apb_write(REG_BOX_COUNT, 64'd7);
        apb_write(REG_EDGE_COLOR, 64'hFFFF);
        apb_write(REG_BOX0, {24'd0, 10'd5, 10'd40, 10'd0, 10'd50});
        apb_write(REG_BOX1, {24'd0, 10'd4, 10'd1023, 10'd0, 10'd1000});
        apb_write(REG_BOX2, {24'd0, 10'd1023, 10'd1023, 10'd0, 10'd0});
        apb_write(REG_BOX3, {24'd0, 10'd6, 10'd20, 10'd1, 10'd8});
        apb_write(REG_SPARE0, '1);
        apb_write(REG_SPARE1, '1);
        for (int i = 0; i < 12; i++)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), i == 0);

        // several rows plus column wraps, no stalls on either side
        steady = 1'b1;
        for (int i = 0; i < SWEEP_PIXELS; i++)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), i == 0);
        settle();
        steady = 1'b0;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            cnt   = (ph == 1) ? 3'd0 : (ph == 2) ? 3'd7 : (ph == 5) ? 3'd4
                  : 3'($urandom_range(1, 7));
            color = (ph == 1) ? 16'h0000 : (ph == 2) ? 16'hFFFF : 16'($urandom_range(65535));
            apb_write(REG_BOX_COUNT, {61'd0, cnt});
            apb_write(REG_EDGE_COLOR, {48'd0, color});
            apb_write(REG_BOX0, (ph == 6) ? {24'd0, {CORNER_W{1'b1}}} : {24'd0, rand_corners()});
            apb_write(REG_BOX1, (ph == 6) ? 64'd0 : {24'd0, rand_corners()});
            apb_write(REG_BOX2, {24'd0, rand_corners()});
            apb_write(REG_BOX3, {24'd0, rand_corners()});
            if (ph == 4)
                apb_write(REG_SPARE0, {$urandom, $urandom});
            phase_id = ph;
            for (int k = 0; k < PHASE_PIXELS; k++)
            begin
                fs = (k == 0 && $urandom_range(3) == 0) || ($urandom_range(399) == 0);
                send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)), fs);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d pixels incl. a steady multi-row run; %0d register writes over %0d settings",
                 pixels_sent, reg_writes, RANDOM_PHASES + 2);
        $display("Checked %0d output beats: %0d box edge pixels, %0d frame ends",
                 pixels_checked, edge_pixels, frame_ends);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
